// ----- rtl/window_size_hint_constrainer_unit_assert.svh -----
// assertion macros for the window size hint constrainer
`ifndef WINDOW_SIZE_HINT_CONSTRAINER_UNIT_ASSERT_SVH
`define WINDOW_SIZE_HINT_CONSTRAINER_UNIT_ASSERT_SVH
// same-cycle implication, clocked on clk, held off during reset
`define WSHC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wshc assertion failed");
// next-cycle implication
`define WSHC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wshc assertion failed");
`endif

// ----- rtl/wshc_pkg.sv -----
// package: types, codes and defaults of the window size hint constrainer
package wshc_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int FRAC_DEF  = 16;

	// command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_RESIZE = 1'b1;

	// record field codes
	localparam logic [3:0] FLD_BASE_W = 4'd0;
	localparam logic [3:0] FLD_BASE_H = 4'd1;
	localparam logic [3:0] FLD_MIN_W  = 4'd2;
	localparam logic [3:0] FLD_MIN_H  = 4'd3;
	localparam logic [3:0] FLD_MAX_W  = 4'd4;
	localparam logic [3:0] FLD_MAX_H  = 4'd5;
	localparam logic [3:0] FLD_STEP_W = 4'd6;
	localparam logic [3:0] FLD_STEP_H = 4'd7;
	localparam logic [3:0] FLD_MIN_A  = 4'd8;
	localparam logic [3:0] FLD_MAX_A  = 4'd9;
	localparam logic [3:0] FLD_FLOAT  = 4'd10;
	localparam logic [3:0] FLD_BORDER = 4'd11;
	localparam logic [3:0] FLD_GX     = 4'd12;
	localparam logic [3:0] FLD_GY     = 4'd13;
	localparam logic [3:0] FLD_GW     = 4'd14;
	localparam logic [3:0] FLD_GH     = 4'd15;

	// configuration register indexes
	localparam logic [2:0] CFG_SCREEN_W = 3'd0;
	localparam logic [2:0] CFG_SCREEN_H = 3'd1;
	localparam logic [2:0] CFG_BAR_H    = 3'd2;
	localparam logic [2:0] CFG_MON_X    = 3'd3;
	localparam logic [2:0] CFG_MON_Y    = 3'd4;
	localparam logic [2:0] CFG_MON_W    = 3'd5;
	localparam logic [2:0] CFG_MON_H    = 3'd6;

	// configuration reset values
	localparam logic [14:0] SCREEN_W_RST = 15'd1920;
	localparam logic [14:0] SCREEN_H_RST = 15'd1080;
	localparam logic [14:0] BAR_H_RST    = 15'd16;
	localparam logic [15:0] MON_X_RST    = 16'd0;
	localparam logic [15:0] MON_Y_RST    = 16'd0;
	localparam logic [14:0] MON_W_RST    = 15'd1920;
	localparam logic [14:0] MON_H_RST    = 15'd1080;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         slot;
		logic [3:0]         field_sel;
		logic [23:0]        field_value;
		logic signed [15:0] req_x;
		logic signed [15:0] req_y;
		logic signed [15:0] req_w;
		logic signed [15:0] req_h;
		logic               interact;
	} item_t;

	typedef struct packed {
		logic signed [15:0] new_x;
		logic signed [15:0] new_y;
		logic [15:0]        new_w;
		logic [15:0]        new_h;
		logic               changed;
	} result_t;

	typedef struct packed {
		logic [15:0]        base_w;
		logic [15:0]        base_h;
		logic [15:0]        min_w;
		logic [15:0]        min_h;
		logic [15:0]        max_w;
		logic [15:0]        max_h;
		logic [15:0]        step_w;
		logic [15:0]        step_h;
		logic [23:0]        min_asp;
		logic [23:0]        max_asp;
		logic [15:0]        border;
		logic               floating;
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic [15:0]        gw;
		logic [15:0]        gh;
	} rec_t;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_CLAMP = 11'b000_0000_0010,
		ST_PRE   = 11'b000_0000_0100,
		ST_MUL1  = 11'b000_0000_1000,
		ST_MUL2  = 11'b000_0001_0000,
		ST_ASP   = 11'b000_0010_0000,
		ST_POST  = 11'b000_0100_0000,
		ST_DIV   = 11'b000_1000_0000,
		ST_ADJ   = 11'b001_0000_0000,
		ST_FIN   = 11'b010_0000_0000,
		ST_WR    = 11'b100_0000_0000
	} state_t;

endpackage

// ----- rtl/window_size_hint_constrainer_unit.sv -----
// window size hint constrainer: record table and resize datapath
// busy after accept: write 1 cycle, plain resize 2, floating resize 54 - ASPECT_FRAC_BITS
// (38 at default), set by the bit-serial remainder unit for the step rules, one bit per cycle
// done strobes the result in the cycle after the last busy cycle, when a new word may be taken
// so one word per 2, 3 or 55 - ASPECT_FRAC_BITS cycles; the receiver cannot stall
// reset clears state and configuration; the record memory is undefined until written
module window_size_hint_constrainer_unit #(
	parameter int SLOTS            = wshc_pkg::SLOTS_DEF,
	parameter int ASPECT_FRAC_BITS = wshc_pkg::FRAC_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  wshc_pkg::item_t   item,
	output logic              done,
	output wshc_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [15:0]       cfg_data
);
	import wshc_pkg::*;

	localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int F   = ASPECT_FRAC_BITS;
	localparam int VW  = 46 - F;
	localparam int CW  = 46;
	localparam int CLW = 22;
	localparam int NW  = $clog2(VW + 1);

	// slot index modulo the table depth, one restoring step per slot bit
	function automatic logic [AW-1:0] slot_index(input logic [5:0] s);
		logic [12:0] r;
		r = '0;
		for (int i = 5; i >= 0; i--) begin
			r = {r[11:0], s[i]};
			if (r >= 13'(SLOTS)) r = r - 13'(SLOTS);
		end
		return r[AW-1:0];
	endfunction

	state_t state_q;
	item_t  item_q;
	logic [AW-1:0] addr_q;
	rec_t   rd_q;
	rec_t   mem [SLOTS];
	logic   mem_we;
	rec_t   mem_wd;
	logic   accept;

	logic [14:0] screen_w_q, screen_h_q, bar_h_q, mon_w_q, mon_h_q;
	logic signed [15:0] mon_x_q, mon_y_q;

	logic signed [CLW-1:0] x_q, y_q;
	logic signed [VW-1:0]  w_q, h_q;
	logic signed [CW-1:0]  pa_q, pb_q;
	logic [VW-1:0]         dw_q, dh_q;
	logic [16:0]           rw_q, rh_q;
	logic [NW-1:0]         cnt_q;
	logic                  bim;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign bim    = (rd_q.base_w == rd_q.min_w) && (rd_q.base_h == rd_q.min_h);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q <= SCREEN_W_RST;
			screen_h_q <= SCREEN_H_RST;
			bar_h_q    <= BAR_H_RST;
			mon_x_q    <= MON_X_RST;
			mon_y_q    <= MON_Y_RST;
			mon_w_q    <= MON_W_RST;
			mon_h_q    <= MON_H_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SCREEN_W: screen_w_q <= cfg_data[14:0];
				CFG_SCREEN_H: screen_h_q <= cfg_data[14:0];
				CFG_BAR_H:    bar_h_q    <= cfg_data[14:0];
				CFG_MON_X:    mon_x_q    <= cfg_data;
				CFG_MON_Y:    mon_y_q    <= cfg_data;
				CFG_MON_W:    mon_w_q    <= cfg_data[14:0];
				CFG_MON_H:    mon_h_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// record memory, registered read at accept; busy keeps write and read apart
	always_ff @(posedge clk) begin
		if (mem_we) mem[addr_q] <= mem_wd;
		if (accept) rd_q <= mem[slot_index(item.slot)];
	end

	// clamp to screen or monitor, then bar height as least size
	logic signed [CLW-1:0] bw2, wid, hei, lim_x, lim_y, org_x, org_y;
	logic signed [CLW-1:0] cx, cy, cw, ch, bh;
	always_comb begin
		bw2 = $signed({{(CLW-17){1'b0}}, rd_q.border, 1'b0});
		wid = $signed({{(CLW-16){1'b0}}, rd_q.gw}) + bw2;
		hei = $signed({{(CLW-16){1'b0}}, rd_q.gh}) + bw2;
		bh  = $signed({{(CLW-15){1'b0}}, bar_h_q});
		if (item_q.interact) begin
			lim_x = $signed({{(CLW-15){1'b0}}, screen_w_q});
			lim_y = $signed({{(CLW-15){1'b0}}, screen_h_q});
			org_x = '0;
			org_y = '0;
		end else begin
			org_x = CLW'(mon_x_q);
			org_y = CLW'(mon_y_q);
			lim_x = org_x + $signed({{(CLW-15){1'b0}}, mon_w_q});
			lim_y = org_y + $signed({{(CLW-15){1'b0}}, mon_h_q});
		end
		cx = CLW'(item_q.req_x);
		cy = CLW'(item_q.req_y);
		cw = (item_q.req_w < 16'sd1) ? CLW'(1) : CLW'(item_q.req_w);
		ch = (item_q.req_h < 16'sd1) ? CLW'(1) : CLW'(item_q.req_h);
		if (cx > lim_x) cx = lim_x - wid;
		if (cy > lim_y) cy = lim_y - hei;
		if (cx + cw + bw2 < org_x) cx = org_x;
		if (cy + ch + bw2 < org_y) cy = org_y;
		if (ch < bh) ch = bh;
		if (cw < bh) cw = bh;
	end

	// base sizes as signed values
	logic signed [VW-1:0] base_w_s, base_h_s;
	assign base_w_s = $signed({{(VW-16){1'b0}}, rd_q.base_w});
	assign base_h_s = $signed({{(VW-16){1'b0}}, rd_q.base_h});

	// aspect tests and rounded products
	logic signed [CW-1:0] rhs_a, rhs_b, na, nb, qa, qb;
	logic signed [17:0]   w18, h18;
	logic                 below_a, below_b, asp_on;
	always_comb begin
		w18   = w_q[17:0];
		h18   = h_q[17:0];
		rhs_a = CW'(w18) <<< F;
		rhs_b = CW'(h18) <<< F;
		if (h18 > 18'sd0)      below_a = pa_q < rhs_a;
		else if (h18 < 18'sd0) below_a = pa_q > rhs_a;
		else                   below_a = w18 > 18'sd0;
		if (w18 > 18'sd0)      below_b = pb_q < rhs_b;
		else if (w18 < 18'sd0) below_b = pb_q > rhs_b;
		else                   below_b = h18 > 18'sd0;
		na = pa_q + (CW'(1) <<< (F - 1));
		nb = pb_q + (CW'(1) <<< (F - 1));
		qa = na >>> F;
		qb = nb >>> F;
		if (na < 0 && na[F-1:0] != '0) qa = qa + CW'(1);
		if (nb < 0 && nb[F-1:0] != '0) qb = qb + CW'(1);
		asp_on = (rd_q.min_asp != '0) && (rd_q.max_asp != '0);
	end

	// base removal after aspect, magnitudes for the remainder unit
	logic signed [VW-1:0] pw, ph;
	always_comb begin
		pw = bim ? w_q - base_w_s : w_q;
		ph = bim ? h_q - base_h_s : h_q;
	end

	// one restoring remainder step for width and height
	logic [16:0] rw_t, rh_t;
	always_comb begin
		rw_t = {rw_q[15:0], dw_q[VW-1]};
		rh_t = {rh_q[15:0], dh_q[VW-1]};
		if (rw_t >= {1'b0, rd_q.step_w}) rw_t = rw_t - {1'b0, rd_q.step_w};
		if (rh_t >= {1'b0, rd_q.step_h}) rh_t = rh_t - {1'b0, rd_q.step_h};
	end

	// remainder taken off with the sign of the value, base added back
	logic signed [VW-1:0] sw_rem, sh_rem;
	always_comb begin
		sw_rem = '0;
		sh_rem = '0;
		if (rd_q.step_w != '0)
			sw_rem = w_q[VW-1] ? -$signed(VW'(rw_q)) : $signed(VW'(rw_q));
		if (rd_q.step_h != '0)
			sh_rem = h_q[VW-1] ? -$signed(VW'(rh_q)) : $signed(VW'(rh_q));
	end

	// min and max hints, saturation and change test
	logic signed [VW-1:0] fw, fh;
	logic signed [15:0]   fx16, fy16;
	logic [15:0]          fw16, fh16;
	logic                 chg;
	rec_t                 fin_rec, wr_rec;
	always_comb begin
		fw = w_q;
		fh = h_q;
		if (rd_q.floating) begin
			if (fw < $signed({{(VW-16){1'b0}}, rd_q.min_w}))
				fw = $signed({{(VW-16){1'b0}}, rd_q.min_w});
			if (fh < $signed({{(VW-16){1'b0}}, rd_q.min_h}))
				fh = $signed({{(VW-16){1'b0}}, rd_q.min_h});
			if (rd_q.max_w != '0 && fw > $signed({{(VW-16){1'b0}}, rd_q.max_w}))
				fw = $signed({{(VW-16){1'b0}}, rd_q.max_w});
			if (rd_q.max_h != '0 && fh > $signed({{(VW-16){1'b0}}, rd_q.max_h}))
				fh = $signed({{(VW-16){1'b0}}, rd_q.max_h});
		end
		if (x_q < -CLW'(32768))    fx16 = -16'sd32768;
		else if (x_q > CLW'(32767)) fx16 = 16'sd32767;
		else                        fx16 = x_q[15:0];
		if (y_q < -CLW'(32768))    fy16 = -16'sd32768;
		else if (y_q > CLW'(32767)) fy16 = 16'sd32767;
		else                        fy16 = y_q[15:0];
		if (fw < 0)                  fw16 = '0;
		else if (fw > VW'(65535))    fw16 = 16'hFFFF;
		else                         fw16 = fw[15:0];
		if (fh < 0)                  fh16 = '0;
		else if (fh > VW'(65535))    fh16 = 16'hFFFF;
		else                         fh16 = fh[15:0];
		chg = (fx16 != rd_q.gx) || (fy16 != rd_q.gy) || (fw16 != rd_q.gw) ||
			(fh16 != rd_q.gh);
		fin_rec    = rd_q;
		fin_rec.gx = fx16;
		fin_rec.gy = fy16;
		fin_rec.gw = fw16;
		fin_rec.gh = fh16;
	end

	// field write into the record
	always_comb begin
		wr_rec = rd_q;
		unique case (item_q.field_sel)
			FLD_BASE_W: wr_rec.base_w   = item_q.field_value[15:0];
			FLD_BASE_H: wr_rec.base_h   = item_q.field_value[15:0];
			FLD_MIN_W:  wr_rec.min_w    = item_q.field_value[15:0];
			FLD_MIN_H:  wr_rec.min_h    = item_q.field_value[15:0];
			FLD_MAX_W:  wr_rec.max_w    = item_q.field_value[15:0];
			FLD_MAX_H:  wr_rec.max_h    = item_q.field_value[15:0];
			FLD_STEP_W: wr_rec.step_w   = item_q.field_value[15:0];
			FLD_STEP_H: wr_rec.step_h   = item_q.field_value[15:0];
			FLD_MIN_A:  wr_rec.min_asp  = item_q.field_value;
			FLD_MAX_A:  wr_rec.max_asp  = item_q.field_value;
			FLD_FLOAT:  wr_rec.floating = item_q.field_value[0];
			FLD_BORDER: wr_rec.border   = item_q.field_value[15:0];
			FLD_GX:     wr_rec.gx       = item_q.field_value[15:0];
			FLD_GY:     wr_rec.gy       = item_q.field_value[15:0];
			FLD_GW:     wr_rec.gw       = item_q.field_value[15:0];
			FLD_GH:     wr_rec.gh       = item_q.field_value[15:0];
			default: ;
		endcase
	end

	// memory write-back
	always_comb begin
		mem_we = 1'b0;
		mem_wd = wr_rec;
		if (state_q == ST_WR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_FIN) begin
			mem_we = chg;
			mem_wd = fin_rec;
		end
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= (item.cmd == CMD_RESIZE) ? ST_CLAMP : ST_WR;
				end
				ST_CLAMP: state_q <= rd_q.floating ? ST_PRE : ST_FIN;
				ST_PRE:   state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_ASP;
				ST_ASP:   state_q <= ST_POST;
				ST_POST: begin
					cnt_q   <= NW'(VW);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - NW'(1);
					if (cnt_q == NW'(1)) state_q <= ST_ADJ;
				end
				ST_ADJ: state_q <= ST_FIN;
				ST_FIN: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_WR: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			addr_q <= slot_index(item.slot);
		end
		unique case (state_q)
			ST_CLAMP: begin
				x_q <= cx;
				y_q <= cy;
				w_q <= VW'(cw);
				h_q <= VW'(ch);
			end
			ST_PRE: begin
				if (!bim) begin
					w_q <= w_q - base_w_s;
					h_q <= h_q - base_h_s;
				end
			end
			ST_MUL1: pa_q <= CW'($signed({1'b0, rd_q.max_asp}) * h18);
			ST_MUL2: pb_q <= CW'($signed({1'b0, rd_q.min_asp}) * w18);
			ST_ASP: begin
				if (asp_on && below_a)      w_q <= qa[VW-1:0];
				else if (asp_on && below_b) h_q <= qb[VW-1:0];
			end
			ST_POST: begin
				w_q  <= pw;
				h_q  <= ph;
				dw_q <= pw[VW-1] ? VW'(-pw) : VW'(pw);
				dh_q <= ph[VW-1] ? VW'(-ph) : VW'(ph);
				rw_q <= '0;
				rh_q <= '0;
			end
			ST_DIV: begin
				dw_q <= dw_q << 1;
				dh_q <= dh_q << 1;
				rw_q <= rw_t;
				rh_q <= rh_t;
			end
			ST_ADJ: begin
				w_q <= w_q - sw_rem + base_w_s;
				h_q <= h_q - sh_rem + base_h_s;
			end
			ST_FIN: begin
				result.new_x   <= fx16;
				result.new_y   <= fy16;
				result.new_w   <= fw16;
				result.new_h   <= fh16;
				result.changed <= chg;
			end
			ST_WR:   result <= '0;
			default: ;
		endcase
	end

	`include "window_size_hint_constrainer_unit_assert.svh"

	`WSHC_ASSERT_NXT(a_accept_busy, accept, busy)
	`WSHC_ASSERT_NXT(a_done_single, done, !done)
	`WSHC_ASSERT_IMP(a_done_idle, done, !busy)
	`WSHC_ASSERT_IMP(a_write_zero, done && (item_q.cmd == CMD_WRITE), result == '0)
	`WSHC_ASSERT_IMP(a_mem_we_busy, mem_we, busy)

endmodule
